>>> rtl/range_assign_prefix_limit_tree_macros.svh
// assertion macros shared by the rtl files
`ifndef RANGE_ASSIGN_PREFIX_LIMIT_TREE_MACROS_SVH
`define RANGE_ASSIGN_PREFIX_LIMIT_TREE_MACROS_SVH
`ifndef SYNTHESIS
`define RAPL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RAPL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RAPL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RAPL_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/rapl_pkg.sv
`timescale 1ns / 1ps
package rapl_pkg;
    localparam int LEAF_COUNT  = 1024;
    localparam int IDX_W       = $clog2(LEAF_COUNT);
    localparam int KEY_W       = IDX_W + 1;
    localparam int LEN_W       = IDX_W + 1;
    localparam int NODE_DEPTH  = 2 * LEAF_COUNT;
    localparam int SUM_W       = 48;
    localparam int VAL_W       = 32;
    localparam int STACK_DEPTH = IDX_W + 1;
    localparam int STK_IW      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam logic CMD_ASSIGN = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_RD, ST_EVAL, ST_RUN,
        ST_MK_L, ST_MK_R, ST_DONE, ST_RET, ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] total;
        logic signed [SUM_W-1:0] best;
        logic signed [VAL_W-1:0] pend_val;
        logic                    pend_flag;
    } node_t;

    typedef struct packed {
        logic [KEY_W-1:0]        k;
        logic [IDX_W-1:0]        lo;
        logic [IDX_W-1:0]        hi;
        logic                    right;
        logic signed [SUM_W-1:0] lt;
        logic signed [SUM_W-1:0] lb;
    } frame_t;

    typedef struct packed {
        logic                    valid;
        logic                    command;
        logic [IDX_W-1:0]        first_index;
        logic [IDX_W-1:0]        final_index;
        logic signed [VAL_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] position;
    } res_t;
endpackage

>>> rtl/range_assign_prefix_limit_tree.sv
`timescale 1ns / 1ps
`include "range_assign_prefix_limit_tree_macros.svh"
// channel  | handshake          | payload
// config   | cfg_wr_en          | cfg_wr_data (last_index)
// input    | s_valid / s_ready  | s_command, s_first_index, s_final_index, s_amount
// result   | m_valid / m_ready  | m_position
// node visit, single-port node memory: ST_RD, ST_EVAL, ST_RUN, ST_MK_L/R if marking, ST_DONE
// an assign visits up to about 40 nodes; split nodes are combined in ST_RET on the way back
// a query makes two visits per tree level
// reset (ST_INIT) and a last_index write made while idle both put a pending zero on the root
// s_ready is high only while the walker is idle; a finished query waits in the output
// register, and the walker stalls only when a second result is ready before the first is taken
module range_assign_prefix_limit_tree (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rapl_pkg::IDX_W-1:0]         cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [rapl_pkg::IDX_W-1:0]         s_first_index,
    input  logic [rapl_pkg::IDX_W-1:0]         s_final_index,
    input  logic signed [rapl_pkg::VAL_W-1:0]  s_amount,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rapl_pkg::IDX_W-1:0]         m_position
);
    import rapl_pkg::*;

    logic [IDX_W-1:0] last_index_reg;
    logic [IDX_W-1:0] top;
    logic             m_valid_reg;
    logic [IDX_W-1:0] m_position_reg;
    req_t             req;
    res_t             res;
    logic             req_ready;
    logic             res_ready;

    assign top = (last_index_reg > IDX_W'(LEAF_COUNT - 1)) ? IDX_W'(LEAF_COUNT - 1)
                                                          : last_index_reg;
    assign req.valid       = s_valid;
    assign req.command     = s_command;
    assign req.first_index = s_first_index;
    assign req.final_index = s_final_index;
    assign req.amount      = s_amount;
    assign s_ready   = req_ready;
    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_index_reg <= IDX_W'(LEAF_COUNT - 1);
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) last_index_reg <= cfg_wr_data;
            if (res.valid) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) m_position_reg <= res.position;
    end

    rapl_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr       (cfg_wr_en),
        .top       (top),
        .req       (req),
        .req_ready (req_ready),
        .res       (res),
        .res_ready (res_ready)
    );

    `RAPL_ASSERT_IMP(a_res_slot, aclk, aresetn, res.valid, !m_valid_reg || m_ready)
    `RAPL_ASSERT_NXT(a_res_loaded, aclk, aresetn, res.valid, m_valid_reg)
    `RAPL_ASSERT_IMP(a_cfg_blocks_in, aclk, aresetn, cfg_wr_en, !s_ready)
endmodule

>>> rtl/rapl_walker.sv
`timescale 1ns / 1ps
`include "range_assign_prefix_limit_tree_macros.svh"
module rapl_walker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clr,
    input  logic [rapl_pkg::IDX_W-1:0]    top,
    input  rapl_pkg::req_t                req,
    output logic                          req_ready,
    output rapl_pkg::res_t                res,
    input  logic                          res_ready
);
    import rapl_pkg::*;

    state_t state_reg, state_next;

    node_t mem [NODE_DEPTH];
    node_t rd_reg;
    logic             mem_we;
    logic [KEY_W-1:0] mem_addr;
    node_t            mem_wdata;

    frame_t stack_reg [STACK_DEPTH];
    logic              stk_we;
    logic [STK_IW-1:0] stk_idx;
    frame_t            stk_wdata;
    frame_t            f;
    logic [STK_IW-1:0] top_idx;

    logic [KEY_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] lo_reg, lo_next, hi_reg, hi_next, phi_reg, phi_next;
    logic             qphase_reg, qphase_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic signed [SUM_W-1:0] limit_reg, limit_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic signed [SUM_W-1:0] ret_total_reg, ret_total_next, ret_best_reg, ret_best_next;

    logic                    cmd_reg;
    logic [IDX_W-1:0]        a_reg, b_reg;
    logic signed [VAL_W-1:0] v_reg;
    logic                    cov_reg, dis_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic signed [SUM_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] cur_total_reg, cur_best_reg;

    logic                    is_assign, cov, dis;
    logic signed [VAL_W-1:0] sel;
    logic [LEN_W-1:0]        len;
    logic signed [LEN_W+VAL_W:0] prod;
    logic [IDX_W:0]          sum_lh, fsum;
    logic [IDX_W-1:0]        mid, fmid;
    logic                    run_on;
    logic signed [SUM_W-1:0] run_best, node_total_n, node_best_n;
    logic signed [SUM_W-1:0] cmb_total, cmb_right, cmb_best;

    assign is_assign = (cmd_reg == CMD_ASSIGN);
    assign cov = is_assign && (a_reg <= lo_reg) && (hi_reg <= b_reg);
    assign dis = !is_assign || (hi_reg < a_reg) || (lo_reg > b_reg);
    assign sel = cov ? v_reg : rd_reg.pend_val;
    assign len = {1'b0, hi_reg} - {1'b0, lo_reg} + LEN_W'(1);
    assign prod = $signed({1'b0, len}) * sel;
    assign sum_lh = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid = sum_lh[IDX_W:1];

    assign run_on = cov_reg || rd_reg.pend_flag;
    assign run_best = (val_reg > 0) ? prod_reg
                                    : {{(SUM_W-VAL_W){val_reg[VAL_W-1]}}, val_reg};
    assign node_total_n = run_on ? prod_reg : rd_reg.total;
    assign node_best_n  = run_on ? run_best : rd_reg.best;

    assign top_idx = STK_IW'(sp_reg - SP_W'(1));
    assign f = stack_reg[top_idx];
    assign fsum = {1'b0, f.lo} + {1'b0, f.hi};
    assign fmid = fsum[IDX_W:1];
    assign cmb_total = f.lt + ret_total_reg;
    assign cmb_right = f.lt + ret_best_reg;
    assign cmb_best = (f.lb > cmb_right) ? f.lb : cmb_right;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_INIT;
            sp_reg     <= '0;
            qphase_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            qphase_reg <= qphase_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        phi_reg       <= phi_next;
        limit_reg     <= limit_next;
        pos_reg       <= pos_next;
        ret_total_reg <= ret_total_next;
        ret_best_reg  <= ret_best_next;
        if (state_reg == ST_IDLE && req.valid && req_ready) begin
            cmd_reg <= req.command;
            a_reg   <= req.first_index;
            b_reg   <= req.final_index;
            v_reg   <= req.amount;
        end
        if (state_reg == ST_EVAL) begin
            cov_reg  <= cov;
            dis_reg  <= dis;
            val_reg  <= sel;
            prod_reg <= {{(SUM_W-LEN_W-VAL_W-1){prod[LEN_W+VAL_W]}}, prod};
        end
        if (state_reg == ST_RUN) begin
            cur_total_reg <= node_total_n;
            cur_best_reg  <= node_best_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        if (state_reg == ST_RD) rd_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) stack_reg[stk_idx] <= stk_wdata;
    end

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        phi_next       = phi_reg;
        qphase_next    = qphase_reg;
        sp_next        = sp_reg;
        limit_next     = limit_reg;
        pos_next       = pos_reg;
        ret_total_next = ret_total_reg;
        ret_best_next  = ret_best_reg;
        mem_we         = 1'b0;
        mem_addr       = k_reg;
        mem_wdata      = '0;
        stk_we         = 1'b0;
        stk_idx        = top_idx;
        stk_wdata      = f;
        req_ready      = 1'b0;
        res            = '0;
        case (state_reg)
            ST_INIT: begin
                // root gets a pending zero, which hides whatever the store holds
                mem_we             = 1'b1;
                mem_addr           = KEY_W'(1);
                mem_wdata.pend_flag = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_IDLE: begin
                req_ready = !clr;
                if (clr) begin
                    mem_we              = 1'b1;
                    mem_addr            = KEY_W'(1);
                    mem_wdata.pend_flag = 1'b1;
                end else if (req.valid) begin
                    k_next      = KEY_W'(1);
                    lo_next     = '0;
                    hi_next     = top;
                    sp_next     = '0;
                    qphase_next = 1'b0;
                    limit_next  = {{(SUM_W-VAL_W){req.amount[VAL_W-1]}}, req.amount};
                    state_next  = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (run_on && (cov_reg || dis_reg)) begin
                    mem_we          = 1'b1;
                    mem_wdata.total = node_total_n;
                    mem_wdata.best  = node_best_n;
                end
                state_next = (run_on && (lo_reg != hi_reg)) ? ST_MK_L : ST_DONE;
            end
            ST_MK_L: begin
                mem_we             = 1'b1;
                mem_addr           = {k_reg[KEY_W-2:0], 1'b0};
                mem_wdata.pend_val = val_reg;
                mem_wdata.pend_flag = 1'b1;
                state_next         = ST_MK_R;
            end
            ST_MK_R: begin
                mem_we             = 1'b1;
                mem_addr           = {k_reg[KEY_W-2:0], 1'b1};
                mem_wdata.pend_val = val_reg;
                mem_wdata.pend_flag = 1'b1;
                state_next         = ST_DONE;
            end
            ST_DONE: begin
                if (is_assign) begin
                    if (!cov_reg && !dis_reg) begin
                        // partial overlap: descend left, combine on the way back
                        stk_we          = 1'b1;
                        stk_idx         = STK_IW'(sp_reg);
                        stk_wdata       = '0;
                        stk_wdata.k     = k_reg;
                        stk_wdata.lo    = lo_reg;
                        stk_wdata.hi    = hi_reg;
                        sp_next         = sp_reg + SP_W'(1);
                        k_next          = {k_reg[KEY_W-2:0], 1'b0};
                        hi_next         = mid;
                        state_next      = ST_RD;
                    end else begin
                        ret_total_next = cur_total_reg;
                        ret_best_next  = cur_best_reg;
                        state_next     = ST_RET;
                    end
                end else if (!qphase_reg) begin
                    if (lo_reg == hi_reg) begin
                        if (cur_best_reg > limit_reg) begin
                            pos_next   = lo_reg - IDX_W'(1);
                            state_next = (lo_reg == '0) ? ST_IDLE : ST_OUT;
                        end else begin
                            pos_next   = lo_reg;
                            state_next = ST_OUT;
                        end
                    end else begin
                        phi_next    = hi_reg;
                        k_next      = {k_reg[KEY_W-2:0], 1'b0};
                        hi_next     = mid;
                        qphase_next = 1'b1;
                        state_next  = ST_RD;
                    end
                end else begin
                    // left child settled: go into it, or skip it to the right
                    qphase_next = 1'b0;
                    state_next  = ST_RD;
                    if (!(cur_best_reg > limit_reg)) begin
                        limit_next = limit_reg - cur_total_reg;
                        k_next     = k_reg + KEY_W'(1);
                        lo_next    = hi_reg + IDX_W'(1);
                        hi_next    = phi_reg;
                    end
                end
            end
            ST_RET: begin
                if (sp_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (!f.right) begin
                    stk_we          = 1'b1;
                    stk_wdata.right = 1'b1;
                    stk_wdata.lt    = ret_total_reg;
                    stk_wdata.lb    = ret_best_reg;
                    k_next          = {f.k[KEY_W-2:0], 1'b1};
                    lo_next         = fmid + IDX_W'(1);
                    hi_next         = f.hi;
                    state_next      = ST_RD;
                end else begin
                    mem_we          = 1'b1;
                    mem_addr        = f.k;
                    mem_wdata.total = cmb_total;
                    mem_wdata.best  = cmb_best;
                    ret_total_next  = cmb_total;
                    ret_best_next   = cmb_best;
                    sp_next         = sp_reg - SP_W'(1);
                end
            end
            ST_OUT: begin
                res.valid    = res_ready;
                res.position = pos_reg;
                if (res_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `RAPL_ASSERT_IMP(a_sp_bound, aclk, aresetn, 1'b1, sp_reg <= SP_W'(STACK_DEPTH))
    `RAPL_ASSERT_IMP(a_res_query, aclk, aresetn, res.valid, cmd_reg == CMD_QUERY)
    `RAPL_ASSERT_NXT(a_start_read, aclk, aresetn, req.valid && req_ready, state_reg == ST_RD)
    `RAPL_ASSERT_IMP(a_no_wr_on_read, aclk, aresetn,
        state_reg == ST_RD || state_reg == ST_EVAL, !mem_we)
endmodule
